// ----- rtl/core/vsaq_pkg.sv -----
// Shared types, constants and register indexes for the vital-sign alarm qualifier.
`default_nettype none

package vsaq_pkg;

  // Buzzer pattern codes.
  typedef enum logic [1:0] {
    PAT_WARNING  = 2'd0,
    PAT_CRITICAL = 2'd1,
    PAT_SUCCESS  = 2'd2
  } pattern_t;

  // Alarm source codes.
  typedef enum logic [1:0] {
    SRC_ECG   = 2'd0,
    SRC_PULSE = 2'd1,
    SRC_BP    = 2'd2
  } source_t;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_LEADS_OFF_STABLE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_WEAK_STABLE = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WARNING_COOLDOWN = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BP_CRIT_COOLDOWN = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BP_SPEED_COOLDOWN = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_OVER_PRESSURE = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFLATE_LOW = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFLATE_HIGH = 4'd7;

  // Register reset values.
  localparam logic [15:0] RST_LEADS_OFF_STABLE  = 16'd750;
  localparam logic [15:0] RST_PULSE_WEAK_STABLE = 16'd1500;
  localparam logic [15:0] RST_WARNING_COOLDOWN  = 16'd2000;
  localparam logic [15:0] RST_BP_CRIT_COOLDOWN  = 16'd1000;
  localparam logic [15:0] RST_BP_SPEED_COOLDOWN = 16'd1500;
  localparam logic [11:0] RST_OVER_PRESSURE     = 12'd2100;
  localparam logic [10:0] RST_DEFLATE_LOW       = 11'd200;
  localparam logic [10:0] RST_DEFLATE_HIGH      = 11'd350;

  // Fixed clinical limits.
  localparam logic [8:0]  HR_CRIT_LOW     = 9'd40;
  localparam logic [8:0]  HR_WARN_LOW     = 9'd50;
  localparam logic [8:0]  HR_WARN_HIGH    = 9'd120;
  localparam logic [8:0]  HR_CRIT_HIGH    = 9'd140;
  localparam logic [9:0]  SPO2_FLOOR      = 10'd1;
  localparam logic [9:0]  SPO2_CRIT       = 10'd900;
  localparam logic [9:0]  SPO2_WARN       = 10'd940;
  localparam logic [10:0] SPEED_VALID_MIN = 11'd10;

  // Blood-pressure phase codes.
  localparam logic [2:0] BP_IDLE      = 3'd0;
  localparam logic [2:0] BP_DONE      = 3'd1;
  localparam logic [2:0] BP_ERROR     = 3'd2;
  localparam logic [2:0] BP_DEFLATING = 3'd3;

  // Result slots of one update, in emission order.
  localparam int SLOT_COUNT   = 4;
  localparam int SLOT_ECG     = 0;
  localparam int SLOT_PULSE   = 1;
  localparam int SLOT_BP_CRIT = 2;
  localparam int SLOT_BP_END  = 3;

  // Queue depth between the classifier and the emitter.
  localparam int QUEUE_DEPTH = 4;

  // One classified update: which slots fire and the variable patterns.
  typedef struct packed {
    logic [SLOT_COUNT-1:0] mask;
    pattern_t              pulse_pattern;
    pattern_t              bp_pattern;
  } job_t;

endpackage

`default_nettype wire

// ----- rtl/core/vsaq_front.sv -----
// Classifier: keeps configuration and qualification state, turns firing updates to jobs.
`default_nettype none

module vsaq_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Update channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [31:0]                         now_ms,
  input  wire logic                                ecg_running,
  input  wire logic                                ecg_leads_off,
  input  wire logic                                pulse_running,
  input  wire logic                                pulse_valid,
  input  wire logic                                pulse_done,
  input  wire logic [9:0]                          oxygen_saturation,
  input  wire logic [8:0]                          heart_rate,
  input  wire logic [2:0]                          bp_phase,
  input  wire logic [11:0]                         cuff_pressure,
  input  wire logic [10:0]                         deflate_speed,
  input  wire logic                                bp_result_valid,
  // Configuration channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [vsaq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [vsaq_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Job queue write side
  output logic                                     push,
  output vsaq_pkg::job_t                           push_job,
  input  wire logic                                full
);

  // Configuration registers.
  logic [15:0] leads_off_stable_ms;
  logic [15:0] pulse_weak_stable_ms;
  logic [15:0] warning_cooldown_ms;
  logic [15:0] bp_critical_cooldown_ms;
  logic [15:0] bp_speed_cooldown_ms;
  logic [11:0] over_pressure_limit;
  logic [10:0] deflate_speed_low;
  logic [10:0] deflate_speed_high;

  // Qualification state.
  logic [31:0] leads_off_start, leads_off_start_next;
  logic [31:0] weak_pulse_start, weak_pulse_start_next;
  logic [31:0] ecg_last_warning, ecg_last_warning_next;
  logic [31:0] pulse_last_warning, pulse_last_warning_next;
  logic [31:0] bp_last_warning, bp_last_warning_next;
  logic [31:0] bp_last_critical, bp_last_critical_next;
  logic        pulse_seen_active, pulse_seen_active_next;
  logic        bp_seen_active, bp_seen_active_next;

  logic        accept;
  logic        ecg_cond, weak_cond;
  logic [31:0] leads_off_eff, weak_eff;
  logic        ecg_fire, pulse_warn_fire, grade_fire;
  logic        grade_crit, grade_warn;
  logic        bp_active, speed_bad, crit_fire, speed_fire, end_success, end_error;
  vsaq_pkg::pattern_t grade_pattern;

  // A stored stamp of zero means never, otherwise the wrapping gap is compared.
  function automatic logic elapsed(input logic [31:0] now, input logic [31:0] since,
                                   input logic [15:0] interval);
    logic [31:0] gap;
    gap = now - since;
    return (since == 32'd0) || (gap >= {16'd0, interval});
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      leads_off_stable_ms     <= vsaq_pkg::RST_LEADS_OFF_STABLE;
      pulse_weak_stable_ms    <= vsaq_pkg::RST_PULSE_WEAK_STABLE;
      warning_cooldown_ms     <= vsaq_pkg::RST_WARNING_COOLDOWN;
      bp_critical_cooldown_ms <= vsaq_pkg::RST_BP_CRIT_COOLDOWN;
      bp_speed_cooldown_ms    <= vsaq_pkg::RST_BP_SPEED_COOLDOWN;
      over_pressure_limit     <= vsaq_pkg::RST_OVER_PRESSURE;
      deflate_speed_low       <= vsaq_pkg::RST_DEFLATE_LOW;
      deflate_speed_high      <= vsaq_pkg::RST_DEFLATE_HIGH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vsaq_pkg::CFG_LEADS_OFF_STABLE:  leads_off_stable_ms     <= cfg_data;
        vsaq_pkg::CFG_PULSE_WEAK_STABLE: pulse_weak_stable_ms    <= cfg_data;
        vsaq_pkg::CFG_WARNING_COOLDOWN:  warning_cooldown_ms     <= cfg_data;
        vsaq_pkg::CFG_BP_CRIT_COOLDOWN:  bp_critical_cooldown_ms <= cfg_data;
        vsaq_pkg::CFG_BP_SPEED_COOLDOWN: bp_speed_cooldown_ms    <= cfg_data;
        vsaq_pkg::CFG_OVER_PRESSURE:     over_pressure_limit     <= cfg_data[11:0];
        vsaq_pkg::CFG_DEFLATE_LOW:       deflate_speed_low       <= cfg_data[10:0];
        vsaq_pkg::CFG_DEFLATE_HIGH:      deflate_speed_high      <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // ECG leads-off qualification.
  always_comb begin
    ecg_cond      = ecg_running && ecg_leads_off;
    leads_off_eff = (leads_off_start == 32'd0) ? now_ms : leads_off_start;
    ecg_fire      = ecg_cond && ((now_ms - leads_off_eff) >= {16'd0, leads_off_stable_ms})
                    && elapsed(now_ms, ecg_last_warning, warning_cooldown_ms);
    leads_off_start_next  = ecg_cond ? leads_off_eff : 32'd0;
    ecg_last_warning_next = !ecg_cond ? 32'd0 : (ecg_fire ? now_ms : ecg_last_warning);
  end

  // Pulse weak-signal qualification and end-of-measurement grading.
  always_comb begin
    weak_cond       = pulse_running && !pulse_valid;
    weak_eff        = (weak_pulse_start == 32'd0) ? now_ms : weak_pulse_start;
    pulse_warn_fire = weak_cond && ((now_ms - weak_eff) >= {16'd0, pulse_weak_stable_ms})
                      && elapsed(now_ms, pulse_last_warning, warning_cooldown_ms);
    weak_pulse_start_next   = weak_cond ? weak_eff : 32'd0;
    pulse_last_warning_next = pulse_warn_fire ? now_ms : pulse_last_warning;
    pulse_seen_active_next  = pulse_running;

    grade_fire = !pulse_running && pulse_seen_active && pulse_done;
    grade_crit = ((oxygen_saturation > vsaq_pkg::SPO2_FLOOR) &&
                  (oxygen_saturation < vsaq_pkg::SPO2_CRIT)) ||
                 ((heart_rate != 9'd0) && ((heart_rate < vsaq_pkg::HR_CRIT_LOW) ||
                                           (heart_rate > vsaq_pkg::HR_CRIT_HIGH)));
    grade_warn = ((oxygen_saturation >= vsaq_pkg::SPO2_CRIT) &&
                  (oxygen_saturation < vsaq_pkg::SPO2_WARN)) ||
                 ((heart_rate != 9'd0) && ((heart_rate < vsaq_pkg::HR_WARN_LOW) ||
                                           (heart_rate > vsaq_pkg::HR_WARN_HIGH)));
    if (grade_crit) begin
      grade_pattern = vsaq_pkg::PAT_CRITICAL;
    end else if (grade_warn) begin
      grade_pattern = vsaq_pkg::PAT_WARNING;
    end else begin
      grade_pattern = vsaq_pkg::PAT_SUCCESS;
    end
  end

  // Blood-pressure run: over-pressure, deflate speed and end of run.
  always_comb begin
    bp_active  = bp_phase >= vsaq_pkg::BP_DEFLATING;
    speed_bad  = ((deflate_speed > vsaq_pkg::SPEED_VALID_MIN) &&
                  (deflate_speed < deflate_speed_low)) ||
                 (deflate_speed > deflate_speed_high);
    crit_fire  = bp_active && (cuff_pressure > over_pressure_limit)
                 && elapsed(now_ms, bp_last_critical, bp_critical_cooldown_ms);
    speed_fire = (bp_phase == vsaq_pkg::BP_DEFLATING) && speed_bad
                 && elapsed(now_ms, bp_last_warning, bp_speed_cooldown_ms);
    end_success = (bp_phase == vsaq_pkg::BP_DONE) && bp_result_valid && bp_seen_active;
    end_error   = (bp_phase == vsaq_pkg::BP_ERROR) && bp_seen_active;
    bp_last_critical_next = crit_fire ? now_ms : bp_last_critical;
    bp_last_warning_next  = speed_fire ? now_ms : bp_last_warning;
    if (bp_active) begin
      bp_seen_active_next = 1'b1;
    end else if (end_success || end_error || (bp_phase == vsaq_pkg::BP_IDLE)) begin
      bp_seen_active_next = 1'b0;
    end else begin
      bp_seen_active_next = bp_seen_active;
    end
  end

  // Job assembly for the queue.
  always_comb begin
    push_job = '0;
    push_job.mask[vsaq_pkg::SLOT_ECG]     = ecg_fire;
    push_job.mask[vsaq_pkg::SLOT_PULSE]   = pulse_warn_fire || grade_fire;
    push_job.mask[vsaq_pkg::SLOT_BP_CRIT] = crit_fire;
    push_job.mask[vsaq_pkg::SLOT_BP_END]  = speed_fire || end_success || end_error;
    push_job.pulse_pattern = pulse_warn_fire ? vsaq_pkg::PAT_WARNING : grade_pattern;
    push_job.bp_pattern    = end_success ? vsaq_pkg::PAT_SUCCESS : vsaq_pkg::PAT_WARNING;
    push = accept && (|push_job.mask);
  end

  // State advances once per accepted update.
  always_ff @(posedge clk) begin
    if (rst) begin
      leads_off_start    <= '0;
      weak_pulse_start   <= '0;
      ecg_last_warning   <= '0;
      pulse_last_warning <= '0;
      bp_last_warning    <= '0;
      bp_last_critical   <= '0;
      pulse_seen_active  <= 1'b0;
      bp_seen_active     <= 1'b0;
    end else if (accept) begin
      leads_off_start    <= leads_off_start_next;
      weak_pulse_start   <= weak_pulse_start_next;
      ecg_last_warning   <= ecg_last_warning_next;
      pulse_last_warning <= pulse_last_warning_next;
      bp_last_warning    <= bp_last_warning_next;
      bp_last_critical   <= bp_last_critical_next;
      pulse_seen_active  <= pulse_seen_active_next;
      bp_seen_active     <= bp_seen_active_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/vsaq_fifo.sv -----
// Short job queue between the classifier and the emitter.
`default_nettype none

module vsaq_fifo #(
  parameter int DEPTH = vsaq_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire vsaq_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output vsaq_pkg::job_t      pop_job,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vsaq_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The classifier never writes a full queue, and the emitter never reads an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job queue read while empty");
  // Only jobs that carry at least one request are queued.
  a_nonempty_job: assert property (@(posedge clk) disable iff (rst)
                                   push |-> (push_job.mask != '0))
    else $error("job with no request queued");
  // Fill count follows the push and pop pattern.
  a_count_track: assert property (@(posedge clk) disable iff (rst)
                                  (push == pop) |=> $stable(count))
    else $error("job queue count moved without net transfer");

endmodule

`default_nettype wire

// ----- rtl/core/vsaq_back.sv -----
// Emitter: walks each queued job, sending its buzzer requests one word per unstalled cycle.
`default_nettype none

module vsaq_back (
  input  wire logic           clk,
  input  wire logic           rst,
  // Job queue read side
  output logic                pop,
  input  wire vsaq_pkg::job_t pop_job,
  input  wire logic           empty,
  // Result channel
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          pattern,
  output logic [1:0]          alarm_source,
  output logic                last_of_run
);

  vsaq_pkg::job_t                  cur;
  logic [vsaq_pkg::SLOT_COUNT-1:0] low_bit;
  logic [vsaq_pkg::SLOT_COUNT-1:0] remaining;
  logic                            adv;
  vsaq_pkg::pattern_t              sel_pattern;
  vsaq_pkg::source_t               sel_source;

  // Pick the earliest pending slot of the current job.
  always_comb begin
    low_bit   = cur.mask & (~cur.mask + 1'b1);
    remaining = cur.mask & ~low_bit;
    adv       = (cur.mask != '0) && (!out_valid || !out_stall);
    pop       = !empty && ((cur.mask == '0) || (adv && (remaining == '0)));
    if (low_bit[vsaq_pkg::SLOT_ECG]) begin
      sel_pattern = vsaq_pkg::PAT_WARNING;
      sel_source  = vsaq_pkg::SRC_ECG;
    end else if (low_bit[vsaq_pkg::SLOT_PULSE]) begin
      sel_pattern = cur.pulse_pattern;
      sel_source  = vsaq_pkg::SRC_PULSE;
    end else if (low_bit[vsaq_pkg::SLOT_BP_CRIT]) begin
      sel_pattern = vsaq_pkg::PAT_CRITICAL;
      sel_source  = vsaq_pkg::SRC_BP;
    end else begin
      sel_pattern = cur.bp_pattern;
      sel_source  = vsaq_pkg::SRC_BP;
    end
  end

  // Current job register: reloads from the queue as the last slot leaves or while empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (pop) begin
      cur <= pop_job;
    end else if (adv) begin
      cur.mask <= remaining;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pattern      <= sel_pattern;
      alarm_source <= sel_source;
      last_of_run  <= (remaining == '0);
    end
  end

  // A request that moves into the output register is always presented next cycle.
  a_adv_shows: assert property (@(posedge clk) disable iff (rst) adv |=> out_valid)
    else $error("request lost on its way to the output register");
  // A new job is only taken once the current one has no pending slot left after this cycle.
  a_pop_when_done: assert property (@(posedge clk) disable iff (rst)
                                    pop |-> ((cur.mask == '0) || (remaining == '0)))
    else $error("job reloaded while requests were still pending");
  // The slot sent is always a single pending bit of the job.
  a_single_slot: assert property (@(posedge clk) disable iff (rst)
                                  adv |-> $onehot(low_bit))
    else $error("emitter selected more than one slot");

endmodule

`default_nettype wire

// ----- rtl/core/vital_sign_alarm_qualifier_unit.sv -----
// Top level of the vital-sign alarm qualifier: classifier, job queue and emitter.
//
// Usage: each monitor snapshot enters as one word on the in_ channel (in_valid,
// in_stall) with its millisecond stamp. The classifier takes one word per cycle
// whenever the job queue has room and updates all qualification timers in that
// cycle. Each update causes zero to four buzzer requests; those that fire are
// queued as one job and leave on the out_ channel in order ECG, pulse,
// blood-pressure critical, blood-pressure warning or end of run, one word per
// cycle while out_stall is low; last_of_run marks the final request of an
// update. Requests pass through the job queue, the current job register and
// the output register. Throughput: one update per cycle while the job queue
// has room, bounded by the emitter at one request per cycle while the receiver
// does not stall; updates with no request are not queued. When the receiver
// stalls the output word holds, the queue fills, and in_stall rises once
// QUEUE_DEPTH jobs wait. Configuration words (cfg_valid, always ready) are to
// be written only while the block is idle; the block itself does not enforce it.
// Reset is synchronous: all timers, cooldown stamps and run flags clear to
// zero, registers return to their defaults and the queue empties.
`default_nettype none

module vital_sign_alarm_qualifier_unit #(
  parameter int QUEUE_DEPTH = vsaq_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Update channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [31:0]                      now_ms,
  input  wire logic                             ecg_running,
  input  wire logic                             ecg_leads_off,
  input  wire logic                             pulse_running,
  input  wire logic                             pulse_valid,
  input  wire logic                             pulse_done,
  input  wire logic [9:0]                       oxygen_saturation,
  input  wire logic [8:0]                       heart_rate,
  input  wire logic [2:0]                       bp_phase,
  input  wire logic [11:0]                      cuff_pressure,
  input  wire logic [10:0]                      deflate_speed,
  input  wire logic                             bp_result_valid,
  // Configuration channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [vsaq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [vsaq_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            pattern,
  output logic [1:0]                            alarm_source,
  output logic                                  last_of_run
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  vsaq_pkg::job_t push_job;
  vsaq_pkg::job_t pop_job;

  // Classifier.
  vsaq_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .now_ms            (now_ms),
    .ecg_running       (ecg_running),
    .ecg_leads_off     (ecg_leads_off),
    .pulse_running     (pulse_running),
    .pulse_valid       (pulse_valid),
    .pulse_done        (pulse_done),
    .oxygen_saturation (oxygen_saturation),
    .heart_rate        (heart_rate),
    .bp_phase          (bp_phase),
    .cuff_pressure     (cuff_pressure),
    .deflate_speed     (deflate_speed),
    .bp_result_valid   (bp_result_valid),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .push_job          (push_job),
    .full              (full)
  );

  // Job queue.
  vsaq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // Emitter.
  vsaq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop          (pop),
    .pop_job      (pop_job),
    .empty        (empty),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pattern      (pattern),
    .alarm_source (alarm_source),
    .last_of_run  (last_of_run)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_vital_sign_alarm_qualifier_unit.sv -----
// Self-checking testbench for the vital-sign alarm qualifier unit.
module tb_vital_sign_alarm_qualifier_unit;

  // One monitor snapshot, as driven onto the update channel.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        ecg_running;
    logic        ecg_leads_off;
    logic        pulse_running;
    logic        pulse_valid;
    logic        pulse_done;
    logic [9:0]  oxygen_saturation;
    logic [8:0]  heart_rate;
    logic [2:0]  bp_phase;
    logic [11:0] cuff_pressure;
    logic [10:0] deflate_speed;
    logic        bp_result_valid;
  } update_t;

  // One buzzer request, as seen on the result channel.
  typedef struct packed {
    vsaq_pkg::pattern_t pat;
    vsaq_pkg::source_t  src;
    logic               last;
  } request_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;
  typedef enum logic [1:0] {BPS_IDLE, BPS_PUMP, BPS_DEFLATE, BPS_END} bp_stage_t;

  localparam int PREDICTED     = -1;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             in_valid = 1'b0;
  logic                             in_stall;
  update_t                          in_word = '0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [vsaq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [vsaq_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [1:0]                       pattern;
  logic [1:0]                       alarm_source;
  logic                             last_of_run;

  vital_sign_alarm_qualifier_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .now_ms           (in_word.now_ms),
    .ecg_running      (in_word.ecg_running),
    .ecg_leads_off    (in_word.ecg_leads_off),
    .pulse_running    (in_word.pulse_running),
    .pulse_valid      (in_word.pulse_valid),
    .pulse_done       (in_word.pulse_done),
    .oxygen_saturation(in_word.oxygen_saturation),
    .heart_rate       (in_word.heart_rate),
    .bp_phase         (in_word.bp_phase),
    .cuff_pressure    (in_word.cuff_pressure),
    .deflate_speed    (in_word.deflate_speed),
    .bp_result_valid  (in_word.bp_result_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pattern          (pattern),
    .alarm_source     (alarm_source),
    .last_of_run      (last_of_run)
  );

  always #4 clk = ~clk;

  // Shadow copy of the registers and of the qualification state.
  logic [15:0] reg_val [8];
  logic [31:0] leads_off_since;
  logic [31:0] weak_pulse_since;
  logic [31:0] ecg_warned_at;
  logic [31:0] pulse_warned_at;
  logic [31:0] bp_warned_at;
  logic [31:0] bp_critical_at;
  logic        pulse_active_seen;
  logic        bp_active_seen;

  request_t    step_reqs [$];
  request_t    pending_requests [$];
  int          canned_n [$];
  logic [15:0] canned_codes [$];
  int          errors = 0;

  // Directed table: stimulus plus, where obvious, the requests it must cause.
  update_t     dir_upd [$];
  int          dir_n [$];
  logic [15:0] dir_codes [$];

  // Sender and random scenario state.
  int          burst_left = 0;
  logic [31:0] clock_ms = 32'd0;
  logic        leads_state = 1'b0;
  logic        pulse_ok = 1'b1;
  int          pulse_left = 0;
  bp_stage_t   bp_stage = BPS_IDLE;
  int          bp_left = 0;
  logic [15:0] plan [8];

  rx_mode_t    rx_mode;
  int          rx_left;

  task automatic reset_shadow();
    reg_val[vsaq_pkg::CFG_LEADS_OFF_STABLE]  = vsaq_pkg::RST_LEADS_OFF_STABLE;
    reg_val[vsaq_pkg::CFG_PULSE_WEAK_STABLE] = vsaq_pkg::RST_PULSE_WEAK_STABLE;
    reg_val[vsaq_pkg::CFG_WARNING_COOLDOWN]  = vsaq_pkg::RST_WARNING_COOLDOWN;
    reg_val[vsaq_pkg::CFG_BP_CRIT_COOLDOWN]  = vsaq_pkg::RST_BP_CRIT_COOLDOWN;
    reg_val[vsaq_pkg::CFG_BP_SPEED_COOLDOWN] = vsaq_pkg::RST_BP_SPEED_COOLDOWN;
    reg_val[vsaq_pkg::CFG_OVER_PRESSURE]     = {4'd0, vsaq_pkg::RST_OVER_PRESSURE};
    reg_val[vsaq_pkg::CFG_DEFLATE_LOW]       = {5'd0, vsaq_pkg::RST_DEFLATE_LOW};
    reg_val[vsaq_pkg::CFG_DEFLATE_HIGH]      = {5'd0, vsaq_pkg::RST_DEFLATE_HIGH};
    leads_off_since   = 32'd0;
    weak_pulse_since  = 32'd0;
    ecg_warned_at     = 32'd0;
    pulse_warned_at   = 32'd0;
    bp_warned_at      = 32'd0;
    bp_critical_at    = 32'd0;
    pulse_active_seen = 1'b0;
    bp_active_seen    = 1'b0;
  endtask

  // Registers keep only their own width; unknown indexes are dropped.
  task automatic store_reg(input logic [vsaq_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] data);
    case (idx)
      vsaq_pkg::CFG_LEADS_OFF_STABLE, vsaq_pkg::CFG_PULSE_WEAK_STABLE,
      vsaq_pkg::CFG_WARNING_COOLDOWN, vsaq_pkg::CFG_BP_CRIT_COOLDOWN,
      vsaq_pkg::CFG_BP_SPEED_COOLDOWN: reg_val[idx] = data;
      vsaq_pkg::CFG_OVER_PRESSURE: reg_val[idx] = {4'd0, data[11:0]};
      vsaq_pkg::CFG_DEFLATE_LOW, vsaq_pkg::CFG_DEFLATE_HIGH: reg_val[idx] = {5'd0, data[10:0]};
      default: ;
    endcase
  endtask

  // A stamp of zero means never, so the cooldown is bypassed.
  function automatic logic cooled(input logic [31:0] now, input logic [31:0] since,
                                  input logic [15:0] gap);
    logic [31:0] span;
    span = now - since;
    return (since == 32'd0) || (span >= {16'd0, gap});
  endfunction

  // Works out the buzzer requests of one update, in emission order.
  task automatic predict_requests(input update_t u);
    logic [31:0] span;
    logic        crit;
    logic        warn;
    step_reqs.delete();

    // ECG leads-off qualification.
    if (u.ecg_running && u.ecg_leads_off) begin
      if (leads_off_since == 32'd0) leads_off_since = u.now_ms;
      span = u.now_ms - leads_off_since;
      if (span >= {16'd0, reg_val[vsaq_pkg::CFG_LEADS_OFF_STABLE]} &&
          cooled(u.now_ms, ecg_warned_at, reg_val[vsaq_pkg::CFG_WARNING_COOLDOWN])) begin
        ecg_warned_at = u.now_ms;
        step_reqs.push_back({vsaq_pkg::PAT_WARNING, vsaq_pkg::SRC_ECG, 1'b0});
      end
    end else begin
      leads_off_since = 32'd0;
      ecg_warned_at   = 32'd0;
    end

    // Pulse oximetry: weak-signal warning while running, grading when done.
    if (u.pulse_running) begin
      pulse_active_seen = 1'b1;
      if (!u.pulse_valid) begin
        if (weak_pulse_since == 32'd0) weak_pulse_since = u.now_ms;
        span = u.now_ms - weak_pulse_since;
        if (span >= {16'd0, reg_val[vsaq_pkg::CFG_PULSE_WEAK_STABLE]} &&
            cooled(u.now_ms, pulse_warned_at,
                   reg_val[vsaq_pkg::CFG_WARNING_COOLDOWN])) begin
          pulse_warned_at = u.now_ms;
          step_reqs.push_back({vsaq_pkg::PAT_WARNING, vsaq_pkg::SRC_PULSE, 1'b0});
        end
      end else begin
        weak_pulse_since = 32'd0;
      end
    end else begin
      weak_pulse_since = 32'd0;
      if (pulse_active_seen && u.pulse_done) begin
        crit = (u.oxygen_saturation > vsaq_pkg::SPO2_FLOOR &&
                u.oxygen_saturation < vsaq_pkg::SPO2_CRIT) ||
               (u.heart_rate != 9'd0 &&
                (u.heart_rate < vsaq_pkg::HR_CRIT_LOW ||
                 u.heart_rate > vsaq_pkg::HR_CRIT_HIGH));
        warn = (u.oxygen_saturation >= vsaq_pkg::SPO2_CRIT &&
                u.oxygen_saturation < vsaq_pkg::SPO2_WARN) ||
               (u.heart_rate != 9'd0 &&
                (u.heart_rate < vsaq_pkg::HR_WARN_LOW ||
                 u.heart_rate > vsaq_pkg::HR_WARN_HIGH));
        if (crit) step_reqs.push_back({vsaq_pkg::PAT_CRITICAL, vsaq_pkg::SRC_PULSE, 1'b0});
        else if (warn) step_reqs.push_back({vsaq_pkg::PAT_WARNING, vsaq_pkg::SRC_PULSE, 1'b0});
        else step_reqs.push_back({vsaq_pkg::PAT_SUCCESS, vsaq_pkg::SRC_PULSE, 1'b0});
      end
      pulse_active_seen = 1'b0;
    end

    // Blood pressure: alarms during the run, outcome at its end.
    if (u.bp_phase >= vsaq_pkg::BP_DEFLATING) begin
      bp_active_seen = 1'b1;
      if (u.cuff_pressure > reg_val[vsaq_pkg::CFG_OVER_PRESSURE][11:0] &&
          cooled(u.now_ms, bp_critical_at, reg_val[vsaq_pkg::CFG_BP_CRIT_COOLDOWN])) begin
        bp_critical_at = u.now_ms;
        step_reqs.push_back({vsaq_pkg::PAT_CRITICAL, vsaq_pkg::SRC_BP, 1'b0});
      end
      if (u.bp_phase == vsaq_pkg::BP_DEFLATING &&
          ((u.deflate_speed > vsaq_pkg::SPEED_VALID_MIN &&
            u.deflate_speed < reg_val[vsaq_pkg::CFG_DEFLATE_LOW][10:0]) ||
           u.deflate_speed > reg_val[vsaq_pkg::CFG_DEFLATE_HIGH][10:0]) &&
          cooled(u.now_ms, bp_warned_at, reg_val[vsaq_pkg::CFG_BP_SPEED_COOLDOWN])) begin
        bp_warned_at = u.now_ms;
        step_reqs.push_back({vsaq_pkg::PAT_WARNING, vsaq_pkg::SRC_BP, 1'b0});
      end
    end else begin
      if (u.bp_phase == vsaq_pkg::BP_DONE && u.bp_result_valid && bp_active_seen) begin
        step_reqs.push_back({vsaq_pkg::PAT_SUCCESS, vsaq_pkg::SRC_BP, 1'b0});
        bp_active_seen = 1'b0;
      end else if (u.bp_phase == vsaq_pkg::BP_ERROR && bp_active_seen) begin
        step_reqs.push_back({vsaq_pkg::PAT_WARNING, vsaq_pkg::SRC_BP, 1'b0});
        bp_active_seen = 1'b0;
      end
      if (u.bp_phase == vsaq_pkg::BP_IDLE) bp_active_seen = 1'b0;
    end
  endtask

  // Queues the requests of an accepted update; typed-in rows override the predictor.
  task automatic accept_update(input update_t u);
    int          n;
    logic [15:0] codes;
    request_t    r;
    n     = canned_n.pop_front();
    codes = canned_codes.pop_front();
    predict_requests(u);
    if (n != PREDICTED) begin
      step_reqs.delete();
      for (int i = 0; i < n; i++) step_reqs.push_back(request_t'({codes[15-4*i -: 4], 1'b0}));
    end
    for (int i = 0; i < step_reqs.size(); i++) begin
      r      = step_reqs[i];
      r.last = (i == step_reqs.size() - 1);
      pending_requests.push_back(r);
    end
  endtask

  task automatic check_request();
    request_t want;
    if (pending_requests.size() == 0) begin
      $error("unexpected request: pattern %0d, alarm_source %0d, last_of_run %0d",
             pattern, alarm_source, last_of_run);
      errors++;
    end else begin
      want = pending_requests.pop_front();
      if (pattern !== want.pat) begin
        $error("pattern: expected %0d, actual %0d", want.pat, pattern);
        errors++;
      end
      if (alarm_source !== want.src) begin
        $error("alarm_source: expected %0d, actual %0d", want.src, alarm_source);
        errors++;
      end
      if (last_of_run !== want.last) begin
        $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
        errors++;
      end
    end
  endtask

  // Monitor: every channel is sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      reset_shadow();
    end else begin
      if (out_valid && !out_stall) check_request();
      if (cfg_valid && cfg_ready) store_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) accept_update(in_word);
    end
  end

  // Receiver: stalls in modes of random length.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_mode   <= RX_FREE;
      rx_left   <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(4, 40);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  function automatic update_t upd(input logic [31:0] now, input logic ecg_run,
                                  input logic leads, input logic p_run, input logic p_ok,
                                  input logic p_done, input logic [9:0] spo2,
                                  input logic [8:0] hr, input logic [2:0] phase,
                                  input logic [11:0] press, input logic [10:0] speed,
                                  input logic bp_ok);
    return {now, ecg_run, leads, p_run, p_ok, p_done, spo2, hr, phase, press, speed, bp_ok};
  endfunction

  function automatic logic [3:0] rq(input vsaq_pkg::pattern_t p, input vsaq_pkg::source_t s);
    return {p, s};
  endfunction

  task automatic add_row(input update_t u, input int n, input logic [15:0] codes);
    dir_upd.push_back(u);
    dir_n.push_back(n);
    dir_codes.push_back(codes);
  endtask

  // Sender: bursts of words with random gaps in between.
  task automatic send_update(input update_t u, input int n, input logic [15:0] codes);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    canned_n.push_back(n);
    canned_codes.push_back(codes);
    in_word  <= u;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Random update drawn from plausible monitor sequences, with some noise.
  function automatic update_t random_update();
    update_t u;
    u = '0;
    case ($urandom_range(0, 19))
      0:       clock_ms = 32'd0;
      1:       clock_ms = $urandom;
      2, 3:    clock_ms = clock_ms + 32'($urandom_range(0, 70000));
      default: clock_ms = clock_ms + 32'($urandom_range(0, 1200));
    endcase
    u.now_ms = clock_ms;

    // ECG leads-off tends to persist over several updates.
    if ($urandom_range(0, 5) == 0) leads_state = ~leads_state;
    u.ecg_running   = ($urandom_range(0, 7) != 0);
    u.ecg_leads_off = ($urandom_range(0, 9) == 0) ? 1'($urandom) : leads_state;

    // Pulse runs last a few updates and usually end with a done flag.
    if ($urandom_range(0, 3) == 0) pulse_ok = ~pulse_ok;
    u.pulse_valid = pulse_ok;
    if (pulse_left != 0) begin
      u.pulse_running = 1'b1;
      u.pulse_done    = ($urandom_range(0, 7) == 0);
      pulse_left--;
    end else begin
      u.pulse_done = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) pulse_left = $urandom_range(1, 6);
    end
    case ($urandom_range(0, 11))
      0:       u.oxygen_saturation = 10'd0;
      1:       u.oxygen_saturation = vsaq_pkg::SPO2_FLOOR;
      2:       u.oxygen_saturation = vsaq_pkg::SPO2_FLOOR + 10'd1;
      3:       u.oxygen_saturation = vsaq_pkg::SPO2_CRIT - 10'd1;
      4:       u.oxygen_saturation = vsaq_pkg::SPO2_CRIT;
      5:       u.oxygen_saturation = vsaq_pkg::SPO2_WARN - 10'd1;
      6:       u.oxygen_saturation = vsaq_pkg::SPO2_WARN;
      7:       u.oxygen_saturation = 10'h3FF;
      8:       u.oxygen_saturation = 10'($urandom);
      default: u.oxygen_saturation = 10'($urandom_range(880, 1000));
    endcase
    case ($urandom_range(0, 13))
      0:       u.heart_rate = 9'd0;
      1:       u.heart_rate = vsaq_pkg::HR_CRIT_LOW - 9'd1;
      2:       u.heart_rate = vsaq_pkg::HR_CRIT_LOW;
      3:       u.heart_rate = vsaq_pkg::HR_WARN_LOW - 9'd1;
      4:       u.heart_rate = vsaq_pkg::HR_WARN_LOW;
      5:       u.heart_rate = vsaq_pkg::HR_WARN_HIGH;
      6:       u.heart_rate = vsaq_pkg::HR_WARN_HIGH + 9'd1;
      7:       u.heart_rate = vsaq_pkg::HR_CRIT_HIGH;
      8:       u.heart_rate = vsaq_pkg::HR_CRIT_HIGH + 9'd1;
      9:       u.heart_rate = 9'h1FF;
      10:      u.heart_rate = 9'($urandom);
      default: u.heart_rate = 9'($urandom_range(30, 160));
    endcase

    // Blood-pressure run: idle, pump, deflate, then done or error.
    u.bp_result_valid = 1'($urandom);
    case (bp_stage)
      BPS_IDLE: begin
        u.bp_phase = vsaq_pkg::BP_IDLE;
        if ($urandom_range(0, 2) == 0) begin
          bp_stage = BPS_PUMP;
          bp_left  = $urandom_range(1, 3);
        end
      end
      BPS_PUMP: begin
        u.bp_phase = vsaq_pkg::BP_DEFLATING + 3'($urandom_range(1, 4));
        if (bp_left > 1) bp_left--;
        else begin
          bp_stage = BPS_DEFLATE;
          bp_left  = $urandom_range(1, 8);
        end
      end
      BPS_DEFLATE: begin
        u.bp_phase = vsaq_pkg::BP_DEFLATING;
        if (bp_left > 1) bp_left--;
        else bp_stage = BPS_END;
      end
      default: begin
        u.bp_phase = ($urandom_range(0, 3) == 0) ? vsaq_pkg::BP_ERROR : vsaq_pkg::BP_DONE;
        u.bp_result_valid = ($urandom_range(0, 3) != 0);
        bp_stage          = BPS_IDLE;
      end
    endcase
    if ($urandom_range(0, 9) == 0) u.bp_phase = 3'($urandom);
    if ($urandom_range(0, 3) == 0) u.cuff_pressure = 12'($urandom);
    else u.cuff_pressure = reg_val[vsaq_pkg::CFG_OVER_PRESSURE][11:0] +
                           12'($urandom_range(0, 6)) - 12'd3;
    case ($urandom_range(0, 11))
      0:       u.deflate_speed = 11'd0;
      1:       u.deflate_speed = vsaq_pkg::SPEED_VALID_MIN;
      2:       u.deflate_speed = vsaq_pkg::SPEED_VALID_MIN + 11'd1;
      3:       u.deflate_speed = reg_val[vsaq_pkg::CFG_DEFLATE_LOW][10:0] - 11'd1;
      4:       u.deflate_speed = reg_val[vsaq_pkg::CFG_DEFLATE_LOW][10:0];
      5:       u.deflate_speed = reg_val[vsaq_pkg::CFG_DEFLATE_HIGH][10:0];
      6:       u.deflate_speed = reg_val[vsaq_pkg::CFG_DEFLATE_HIGH][10:0] + 11'd1;
      7:       u.deflate_speed = 11'h7FF;
      8, 9:    u.deflate_speed = 11'($urandom);
      default: u.deflate_speed = 11'($urandom_range(150, 400));
    endcase
    return u;
  endfunction

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) send_update(random_update(), PREDICTED, 16'h0);
  endtask

  // Ends a phase: drop valid, drain every request, then let the pipeline settle.
  task automatic finish_phase();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_requests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Raises a configuration word and holds it until taken; the caller lowers valid.
  task automatic cfg_write(input logic [vsaq_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes all eight registers from the plan, plus one word to an unused index.
  task automatic apply_plan();
    for (logic [vsaq_pkg::CFG_INDEX_W-1:0] idx = vsaq_pkg::CFG_LEADS_OFF_STABLE;
         idx <= vsaq_pkg::CFG_DEFLATE_HIGH; idx++)
      cfg_write(idx, plan[idx]);
    cfg_write(vsaq_pkg::CFG_DEFLATE_HIGH + 4'($urandom_range(1, 8)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Stimulus sequence.
  initial begin
    // Leads-off qualified after its stable time, then held off by the cooldown.
    add_row(upd(32'd0, 0, 0, 0, 0, 0, 10'd980, 9'd70, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), 0, 16'h0);
    add_row(upd(32'd100, 1, 1, 0, 0, 0, 10'd980, 9'd70, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), 0, 16'h0);
    add_row(upd(32'd850, 1, 1, 0, 0, 0, 10'd980, 9'd70, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0),
            1, {rq(vsaq_pkg::PAT_WARNING, vsaq_pkg::SRC_ECG), 12'h0});
    add_row(upd(32'd1000, 1, 1, 1, 0, 0, 10'd980, 9'd70, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), PREDICTED, 16'h0);
    add_row(upd(32'd2500, 1, 1, 1, 0, 0, 10'd980, 9'd70, 3'd4, 12'd2100, 11'd0, 0),
            PREDICTED, 16'h0);
    // Every source fires at once: the most requests one update can cause.
    add_row(upd(32'd4500, 1, 1, 1, 0, 0, 10'd980, 9'd70, vsaq_pkg::BP_DEFLATING,
                12'd4000, 11'd2000, 0),
            4, {rq(vsaq_pkg::PAT_WARNING, vsaq_pkg::SRC_ECG),
                rq(vsaq_pkg::PAT_WARNING, vsaq_pkg::SRC_PULSE),
                rq(vsaq_pkg::PAT_CRITICAL, vsaq_pkg::SRC_BP),
                rq(vsaq_pkg::PAT_WARNING, vsaq_pkg::SRC_BP)});
    // Pulse grading at each boundary, and the ends of a pressure run.
    add_row(upd(32'd4600, 0, 0, 0, 0, 1, 10'd850, 9'd0, vsaq_pkg::BP_DEFLATING,
                12'd2101, 11'd5, 0), PREDICTED, 16'h0);
    add_row(upd(32'd5600, 0, 0, 1, 1, 0, 10'd980, 9'd70, vsaq_pkg::BP_DEFLATING,
                12'd2101, 11'd199, 0), PREDICTED, 16'h0);
    add_row(upd(32'd5700, 0, 0, 0, 1, 1, 10'd920, 9'd75, vsaq_pkg::BP_ERROR,
                12'd0, 11'd0, 0), PREDICTED, 16'h0);
    add_row(upd(32'd5800, 0, 0, 1, 1, 0, 10'd980, 9'd70, 3'd5, 12'd0, 11'd0, 0),
            PREDICTED, 16'h0);
    add_row(upd(32'd5900, 0, 0, 0, 1, 1, 10'd1000, 9'd141, vsaq_pkg::BP_DONE,
                12'd0, 11'd0, 1), PREDICTED, 16'h0);
    add_row(upd(32'd6000, 0, 0, 1, 1, 0, 10'd980, 9'd70, 3'd6, 12'd0, 11'd0, 0),
            PREDICTED, 16'h0);
    add_row(upd(32'd6100, 0, 0, 0, 1, 1, 10'd980, 9'd80, vsaq_pkg::BP_DONE,
                12'd0, 11'd0, 0), PREDICTED, 16'h0);
    add_row(upd(32'd6200, 0, 0, 1, 1, 0, 10'd980, 9'd70, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), PREDICTED, 16'h0);
    add_row(upd(32'd6300, 0, 0, 0, 1, 1, 10'd1, 9'd45, vsaq_pkg::BP_DONE,
                12'd0, 11'd0, 1), PREDICTED, 16'h0);
    add_row(upd(32'd6400, 0, 0, 1, 1, 0, 10'd980, 9'd70, 3'd7, 12'd0, 11'd0, 0),
            PREDICTED, 16'h0);
    add_row(upd(32'd7000, 0, 0, 0, 1, 1, 10'd0, 9'd121, vsaq_pkg::BP_DEFLATING,
                12'd0, 11'd351, 0), PREDICTED, 16'h0);
    // A done flag with no pulse run before it is not graded.
    add_row(upd(32'd7100, 0, 0, 0, 1, 1, 10'd899, 9'd0, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), 0, 16'h0);
    add_row(upd(32'd7200, 0, 0, 1, 1, 0, 10'd980, 9'd70, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), PREDICTED, 16'h0);
    add_row(upd(32'd7300, 0, 0, 0, 1, 1, 10'd939, 9'd39, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), PREDICTED, 16'h0);
    add_row(upd(32'd7400, 0, 0, 1, 1, 0, 10'd980, 9'd70, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), PREDICTED, 16'h0);
    add_row(upd(32'd7500, 0, 0, 0, 1, 1, 10'd940, 9'd140, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), PREDICTED, 16'h0);
    // A start stamped at time zero reads as unset, so qualification restarts.
    add_row(upd(32'hFFFF_FF00, 0, 0, 0, 0, 0, 10'h3FF, 9'h1FF, vsaq_pkg::BP_IDLE,
                12'hFFF, 11'h7FF, 1), 0, 16'h0);
    add_row(upd(32'd0, 1, 1, 0, 0, 0, 10'd980, 9'd70, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), 0, 16'h0);
    add_row(upd(32'd800, 1, 1, 0, 0, 0, 10'd980, 9'd70, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0), 0, 16'h0);
    add_row(upd(32'd1550, 1, 1, 0, 0, 0, 10'd980, 9'd70, vsaq_pkg::BP_IDLE,
                12'd0, 11'd0, 0),
            1, {rq(vsaq_pkg::PAT_WARNING, vsaq_pkg::SRC_ECG), 12'h0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values of the registers.
    for (int k = 0; k < dir_upd.size(); k++) send_update(dir_upd[k], dir_n[k], dir_codes[k]);
    run_random(24);
    finish_phase();

    // Every register at zero: no stable time, no cooldown, every limit at its floor.
    for (int i = 0; i < 8; i++) plan[i] = 16'h0000;
    apply_plan();
    run_random(20);
    finish_phase();

    // Every register at its top; bits above a register's width are dropped.
    for (int i = 0; i < 8; i++) plan[i] = 16'hFFFF;
    apply_plan();
    run_random(20);
    finish_phase();

    // Random settings with the deflate limits crossed.
    plan[vsaq_pkg::CFG_LEADS_OFF_STABLE]  = 16'($urandom_range(0, 1500));
    plan[vsaq_pkg::CFG_PULSE_WEAK_STABLE] = 16'($urandom_range(0, 3000));
    plan[vsaq_pkg::CFG_WARNING_COOLDOWN]  = 16'($urandom_range(0, 4000));
    plan[vsaq_pkg::CFG_BP_CRIT_COOLDOWN]  = 16'($urandom_range(0, 2000));
    plan[vsaq_pkg::CFG_BP_SPEED_COOLDOWN] = 16'($urandom_range(0, 2000));
    plan[vsaq_pkg::CFG_OVER_PRESSURE]     = 16'($urandom_range(1500, 2700));
    plan[vsaq_pkg::CFG_DEFLATE_LOW]       = 16'($urandom_range(300, 2047));
    plan[vsaq_pkg::CFG_DEFLATE_HIGH]      = 16'($urandom_range(11, 299));
    apply_plan();
    run_random(20);
    finish_phase();

    // Back to the reset values, written explicitly.
    plan[vsaq_pkg::CFG_LEADS_OFF_STABLE]  = vsaq_pkg::RST_LEADS_OFF_STABLE;
    plan[vsaq_pkg::CFG_PULSE_WEAK_STABLE] = vsaq_pkg::RST_PULSE_WEAK_STABLE;
    plan[vsaq_pkg::CFG_WARNING_COOLDOWN]  = vsaq_pkg::RST_WARNING_COOLDOWN;
    plan[vsaq_pkg::CFG_BP_CRIT_COOLDOWN]  = vsaq_pkg::RST_BP_CRIT_COOLDOWN;
    plan[vsaq_pkg::CFG_BP_SPEED_COOLDOWN] = vsaq_pkg::RST_BP_SPEED_COOLDOWN;
    plan[vsaq_pkg::CFG_OVER_PRESSURE]     = {4'd0, vsaq_pkg::RST_OVER_PRESSURE};
    plan[vsaq_pkg::CFG_DEFLATE_LOW]       = {5'd0, vsaq_pkg::RST_DEFLATE_LOW};
    plan[vsaq_pkg::CFG_DEFLATE_HIGH]      = {5'd0, vsaq_pkg::RST_DEFLATE_HIGH};
    apply_plan();
    run_random(20);
    finish_phase();

    if (errors == 0 && pending_requests.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/vsaq_pkg.sv
rtl/core/vsaq_front.sv
rtl/core/vsaq_fifo.sv
rtl/core/vsaq_back.sv
rtl/core/vital_sign_alarm_qualifier_unit.sv
tb/sv/tb_vital_sign_alarm_qualifier_unit.sv
